// ----- rtl/core/oal_pkg.sv -----
// Shared constants and types for the ordered array list unit.
package oal_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_INSERT     = 3'd4;
    localparam logic [2:0] OP_ERASE      = 3'd5;
    localparam logic [2:0] OP_FIND       = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

// ----- rtl/core/oal_store.sv -----
// Entry store: one write port and one registered read port.
module oal_store
    import oal_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ordered_array_list_unit.sv -----
// Ordered array list unit: request sequencer around the entry store.
//
//  channel   signals                                   transfer
//  request   start, busy, i_operation/position/value   start high, busy low
//  result    o_valid, o_status/found/found_index/length one cycle with o_valid
//
//  Push back, pop back, unused codes and any rejected request: result in the cycle after
//  the transfer. Insert and push front shift entries up one place in S_UP, then write the
//  value in S_PUT. Erase and pop front shift entries down one place in S_DOWN when entries
//  move. Find scans in S_FIND up to the first hit or the last entry, skipping an empty
//  list. Reset clears the length; entries are undefined until written. The receiver
//  cannot stall; busy holds off requests until the result.
module ordered_array_list_unit
    import oal_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_operation,
    input  logic [IDX_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic                     o_found,
    output logic [IDX_W-1:0]         o_found_index,
    output logic [LEN_W-1:0]         o_length
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_FIND = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_count, n_count;
    logic              r_strobe, n_strobe;
    logic              r_pend, n_pend;
    logic              r_rd_done, n_rd_done;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [IDX_W-1:0]  r_waddr, n_waddr;
    logic [IDX_W-1:0]  r_lo, n_lo;
    logic [IDX_W-1:0]  r_hi, n_hi;
    logic [DATA_W-1:0] r_val, n_val;
    logic [1:0]        r_status, n_status;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_fidx, n_fidx;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] rdata;
    logic              full;
    logic              empty;
    logic              pos_bad;
    logic              no_move;
    logic [IDX_W-1:0]  last_idx;

    oal_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign full     = (r_count == LEN_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign pos_bad  = ({1'b0, i_position} >= r_count);
    assign no_move  = (({1'b0, i_position} + LEN_W'(1)) >= r_count);
    assign last_idx = IDX_W'(r_count - LEN_W'(1));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_strobe  = 1'b0;
        n_pend    = r_pend;
        n_rd_done = r_rd_done;
        n_ptr     = r_ptr;
        n_waddr   = r_waddr;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_val     = r_val;
        n_status  = r_status;
        n_found   = r_found;
        n_fidx    = r_fidx;
        mem_req.we    = 1'b0;
        mem_req.waddr = r_waddr;
        mem_req.wdata = rdata;
        mem_req.raddr = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status  = ST_OK;
                    n_found   = 1'b0;
                    n_fidx    = '0;
                    n_pend    = 1'b0;
                    n_rd_done = 1'b0;
                    n_val     = i_value;
                    n_lo      = i_position;
                    n_hi      = last_idx;
                    n_strobe  = 1'b1;
                    case (i_operation)
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = IDX_W'(r_count);
                                mem_req.wdata = i_value;
                                n_count       = r_count + LEN_W'(1);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count  = r_count + LEN_W'(1);
                                n_lo     = '0;
                                n_ptr    = last_idx;
                                n_strobe = 1'b0;
                                n_state  = empty ? S_PUT : S_UP;
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - LEN_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - LEN_W'(1);
                                if (r_count > LEN_W'(1)) begin
                                    n_ptr    = IDX_W'(1);
                                    n_strobe = 1'b0;
                                    n_state  = S_DOWN;
                                end
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_count  = r_count + LEN_W'(1);
                                n_ptr    = last_idx;
                                n_strobe = 1'b0;
                                n_state  = S_UP;
                            end
                        end
                        OP_ERASE: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (pos_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_count = r_count - LEN_W'(1);
                                if (!no_move) begin
                                    n_ptr    = i_position + IDX_W'(1);
                                    n_strobe = 1'b0;
                                    n_state  = S_DOWN;
                                end
                            end
                        end
                        OP_FIND: begin
                            if (!empty) begin
                                n_ptr    = '0;
                                n_strobe = 1'b0;
                                n_state  = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP: begin
                mem_req.we = r_pend;
                if (!r_rd_done) begin
                    n_waddr = r_ptr + IDX_W'(1);
                    n_pend  = 1'b1;
                    if (r_ptr == r_lo) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_ptr = r_ptr - IDX_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (r_pend) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_lo;
                mem_req.wdata = r_val;
                n_strobe      = 1'b1;
                n_state       = S_IDLE;
            end
            S_DOWN: begin
                mem_req.we = r_pend;
                if (!r_rd_done) begin
                    n_waddr = r_ptr - IDX_W'(1);
                    n_pend  = 1'b1;
                    if (r_ptr == r_hi) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_ptr = r_ptr + IDX_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_FIND: begin
                if (r_pend && (rdata == r_val)) begin
                    n_found  = 1'b1;
                    n_fidx   = r_waddr;
                    n_pend   = 1'b0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (!r_rd_done) begin
                    n_waddr = r_ptr;
                    n_pend  = 1'b1;
                    if (r_ptr == r_hi) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_ptr = r_ptr + IDX_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_strobe  <= 1'b0;
            r_pend    <= 1'b0;
            r_rd_done <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_strobe  <= n_strobe;
            r_pend    <= n_pend;
            r_rd_done <= n_rd_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_waddr  <= n_waddr;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_val    <= n_val;
        r_status <= n_status;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_strobe;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_found_index = r_fidx;
    assign o_length      = r_count;

endmodule

// ----- dv/tb_ordered_array_list_unit.sv -----
// Self-checking testbench for the ordered array list unit: random and directed requests.
`timescale 1ns / 100ps

module tb_ordered_array_list_unit;
    import oal_pkg::*;

    localparam logic [2:0] OP_RESERVED  = 3'd7;
    localparam int         LIST_PLAN    = 0;
    localparam int         LIST_CHECK   = 1;
    localparam int         RANDOM_ITEMS = 1900;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int         SHOWN_ERRORS = 10;
    localparam int         PHASE_GROW   = 0;
    localparam int         PHASE_SHRINK = 1;

    typedef struct packed {
        logic [2:0]               op;
        logic [IDX_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic [LEN_W-1:0] length;
    } result_t;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     start         = 1'b0;
    logic [2:0]               i_operation   = OP_PUSH_BACK;
    logic [IDX_W-1:0]         i_position    = '0;
    logic signed [DATA_W-1:0] i_value       = '0;
    logic                     busy;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic                     o_found;
    logic [IDX_W-1:0]         o_found_index;
    logic [LEN_W-1:0]         o_length;

    request_t                 pending_requests[$];
    result_t                  expected_results[$];
    logic signed [DATA_W-1:0] list_entries [2][CAPACITY];
    int                       list_len [2] = '{0, 0};

    int      mismatches   = 0;
    int      stall_cycles = 0;
    int      wait_left    = 0;
    int      calm_left    = 0;
    logic    drv_transfer;
    logic    mon_expected;
    result_t want;

    ordered_array_list_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_length      (o_length)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic result_t apply_request(input int sel, input request_t rq);
        result_t r;
        int      n;
        int      k;
        r = '0;
        n = list_len[sel];
        case (rq.op)
            OP_PUSH_BACK: begin
                if (n >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_entries[sel][n] = rq.val;
                    n++;
                end
            end
            OP_PUSH_FRONT: begin
                if (n >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = n; k > 0; k--) begin
                        list_entries[sel][k] = list_entries[sel][k-1];
                    end
                    list_entries[sel][0] = rq.val;
                    n++;
                end
            end
            OP_POP_BACK: begin
                if (n == 0) r.status = ST_EMPTY;
                else n--;
            end
            OP_POP_FRONT: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (k = 0; k + 1 < n; k++) begin
                        list_entries[sel][k] = list_entries[sel][k+1];
                    end
                    n--;
                end
            end
            OP_INSERT: begin
                if (n >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (int'(rq.pos) >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = n; k > int'(rq.pos); k--) begin
                        list_entries[sel][k] = list_entries[sel][k-1];
                    end
                    list_entries[sel][rq.pos] = rq.val;
                    n++;
                end
            end
            OP_ERASE: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(rq.pos) >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = int'(rq.pos); k + 1 < n; k++) begin
                        list_entries[sel][k] = list_entries[sel][k+1];
                    end
                    n--;
                end
            end
            OP_FIND: begin
                for (k = 0; k < n; k++) begin
                    if (!r.found && list_entries[sel][k] === rq.val) begin
                        r.found       = 1'b1;
                        r.found_index = k[IDX_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        list_len[sel] = n;
        r.length      = n[LEN_W-1:0];
        return r;
    endfunction

    task automatic add_request(input logic [2:0] op, input logic [IDX_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
        request_t rq;
        rq.op  = op;
        rq.pos = pos;
        rq.val = val;
        pending_requests.push_back(rq);
        void'(apply_request(LIST_PLAN, rq));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drv_transfer = start && !busy;
            if (drv_transfer) begin
                expected_results.push_back(apply_request(LIST_CHECK, pending_requests[0]));
                void'(pending_requests.pop_front());
                if (calm_left != 0) begin
                    calm_left--;
                    wait_left = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    calm_left = $urandom_range(20, 60);
                    wait_left = 0;
                end else begin
                    wait_left = $urandom_range(0, 11);
                end
            end
            if (start && !drv_transfer) begin
                // hold the request until the block takes it
            end else if (wait_left != 0) begin
                wait_left--;
                start       <= 1'b0;
                i_operation <= 3'($urandom_range(0, 7));
                i_position  <= IDX_W'($urandom_range(0, CAPACITY - 1));
                i_value     <= $urandom;
            end else if (pending_requests.size() != 0) begin
                start       <= 1'b1;
                i_operation <= pending_requests[0].op;
                i_position  <= pending_requests[0].pos;
                i_value     <= pending_requests[0].val;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            mon_expected = o_valid && (expected_results.size() != 0);
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("unexpected result: status %0d found %0d index %0d length %0d",
                                 o_status, o_found, o_found_index, o_length);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status || o_found !== want.found ||
                        o_found_index !== want.found_index || o_length !== want.length) begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS) begin
                            $display("mismatch: expected status %0d found %0d index %0d length %0d",
                                     want.status, want.found, want.found_index, want.length);
                            $display("          got      status %0d found %0d index %0d length %0d",
                                     o_status, o_found, o_found_index, o_length);
                        end
                    end
                end
            end
            stall_cycles <= (mon_expected || (start && !busy)) ? 0 : stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int                       n;
        int                       phase;
        int                       span;
        int                       roll;
        logic [2:0]               op;
        logic [IDX_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        add_request(OP_POP_BACK,   0, 0);
        add_request(OP_POP_FRONT,  0, 0);
        add_request(OP_ERASE,      0, 0);
        add_request(OP_INSERT,     0, 32'sh0000_0011);
        add_request(OP_FIND,       0, 0);
        add_request(OP_RESERVED,   0, 0);
        add_request(OP_PUSH_BACK,  0, 32'sh8000_0000);
        add_request(OP_PUSH_FRONT, 0, 32'sh7FFF_FFFF);
        add_request(OP_PUSH_BACK,  0, 0);
        add_request(OP_PUSH_BACK,  0, -1);
        add_request(OP_INSERT,     1, 32'sh5A5A_5A5A);
        add_request(OP_INSERT,     IDX_W'(CAPACITY - 1), 32'sh0000_0022);
        add_request(OP_ERASE,      5, 0);
        add_request(OP_FIND,       IDX_W'(CAPACITY - 1), 32'sh7FFF_FFFF);
        add_request(OP_FIND,       0, -1);
        add_request(OP_FIND,       0, 32'sh0000_0007);
        add_request(OP_PUSH_BACK,  0, 32'sh7FFF_FFFF);
        add_request(OP_FIND,       0, 32'sh7FFF_FFFF);
        add_request(OP_FIND,       0, 32'sh8000_0000);
        add_request(OP_ERASE,      0, 0);
        add_request(OP_POP_FRONT,  0, 0);
        add_request(OP_RESERVED,   IDX_W'(CAPACITY - 1), -1);
        add_request(OP_ERASE,      2, 0);
        add_request(OP_POP_BACK,   0, 0);
        add_request(OP_INSERT,     0, 32'sh0000_0033);

        while (pending_requests.size() < RANDOM_ITEMS) begin
            phase = $urandom_range(0, 2);
            span  = $urandom_range(20, 100);
            repeat (span) begin
                n    = list_len[LIST_PLAN];
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    op = OP_RESERVED;
                end else if (phase == PHASE_GROW) begin
                    if (roll < 78) begin
                        case ($urandom_range(0, 2))
                            0:       op = OP_PUSH_BACK;
                            1:       op = OP_PUSH_FRONT;
                            default: op = OP_INSERT;
                        endcase
                    end else if (roll < 90) begin
                        op = 3'($urandom_range(OP_POP_BACK, OP_ERASE));
                    end else begin
                        op = OP_FIND;
                    end
                end else if (phase == PHASE_SHRINK) begin
                    if (roll < 78) begin
                        case ($urandom_range(0, 2))
                            0:       op = OP_POP_BACK;
                            1:       op = OP_POP_FRONT;
                            default: op = OP_ERASE;
                        endcase
                    end else if (roll < 90) begin
                        op = 3'($urandom_range(OP_PUSH_BACK, OP_PUSH_FRONT));
                    end else begin
                        op = OP_FIND;
                    end
                end else begin
                    op = 3'($urandom_range(OP_PUSH_BACK, OP_FIND));
                end

                if (n != 0 && $urandom_range(0, 9) < 8) pos = IDX_W'($urandom_range(0, n - 1));
                else pos = IDX_W'($urandom_range(0, CAPACITY - 1));

                if (op == OP_FIND && n != 0 && $urandom_range(0, 9) < 6) begin
                    val = list_entries[LIST_PLAN][$urandom_range(0, n - 1)];
                end else begin
                    case ($urandom_range(0, 9))
                        0:       val = 32'sh8000_0000;
                        1:       val = 32'sh7FFF_FFFF;
                        2:       val = 0;
                        3:       val = -1;
                        4:       val = 1;
                        default: val = $urandom;
                    endcase
                end
                add_request(op, pos, val);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_requests.size() != 0 || expected_results.size() != 0) &&
               stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        if (stall_cycles < STALL_LIMIT) repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (stall_cycles < STALL_LIMIT && mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
